/* rtl/hsv_to_rgb_converter_macros.svh */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_macros
// Assertion macros for the converter checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// concurrent assertion, ignored while reset is asserted
`define H2R_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion, also checked around reset
`define H2R_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/h2r_pkg.sv */
// ----------------------------------------------------------------------------
// h2r_pkg
// Types, constants and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int LEVEL_W = 8;
    localparam int HUE6_W  = 11;
    localparam int PROD_W  = 16;
    localparam int NUM_W   = 24;
    localparam int RECIP_W = 17;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [NUM_W-1:0]   num_t;

    localparam level_t              LEVEL_MAX  = 8'd255;
    localparam logic [HUE6_W-1:0]   SPAN_1     = 11'd255;
    localparam logic [HUE6_W-1:0]   SPAN_2     = 11'd510;
    localparam logic [HUE6_W-1:0]   SPAN_3     = 11'd765;
    localparam logic [HUE6_W-1:0]   SPAN_4     = 11'd1020;
    localparam logic [HUE6_W-1:0]   SPAN_5     = 11'd1275;
    localparam logic [HUE6_W-1:0]   SPAN_6     = 11'd1530;
    // floor(2^24 / 255), under-estimates x/255 by less than one
    localparam logic [RECIP_W-1:0]  RECIP_255  = 17'h10101;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // floor(x / 255), exact for x <= 65025
    function automatic level_t div255_small(input prod_t x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {{(PROD_W-LEVEL_W+1){1'b0}}, x[PROD_W-1:LEVEL_W]} + 17'd1;
        return sum[PROD_W-1:LEVEL_W];
    endfunction

endpackage

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-stage pipelined 8-bit HSV to RGB conversion, exact integer math.
// ----------------------------------------------------------------------------
//  port    dir  content (lsb first)
//  s_*     in   tdata: hue, saturation, brightness
//  m_*     out  tdata: red, green, blue
//
//  One request per cycle unless a stalled output has filled the pipeline.
//  Stages: sector split, products, mid numerator, reciprocal multiply,
//  quotient fix-up, final divide and channel mux.
//  Reset clears the stage valid bits only.
//  A stalled output holds; s_tready stays high while any stage has a bubble.
module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue[7:0], saturation[15:8], brightness[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int STAGES = 6;

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] rdy;

    // stage 1
    sector_t sec1_reg;
    level_t  k1_reg, s1_reg, v1_reg;
    // stage 2
    sector_t sec2_reg;
    level_t  k2_reg, v2_reg;
    prod_t   a2_reg, b2_reg;
    // stage 3
    sector_t sec3_reg;
    level_t  v3_reg;
    prod_t   a3_reg;
    num_t    num3_reg;
    // stage 4
    sector_t sec4_reg;
    level_t  v4_reg, lo4_reg;
    prod_t   q4_reg;
    num_t    num4_reg;
    // stage 5
    sector_t sec5_reg;
    level_t  v5_reg, lo5_reg;
    prod_t   t5_reg;
    // stage 6
    level_t  red_reg, green_reg, blue_reg;

    always_comb
    begin
        rdy[STAGES] = !vld_reg[STAGES] || m_tready;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[STAGES];
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: sector and sector fraction
    level_t              hue_in;
    logic [HUE6_W-1:0]   hue6;
    logic [HUE6_W-1:0]   frac_full;
    sector_t             sec_next;
    level_t              frac;
    level_t              k_next;

    assign hue_in = s_tdata[7:0];
    assign hue6   = {1'b0, hue_in, 2'b00} + {2'b00, hue_in, 1'b0};

    always_comb
    begin
        priority if (hue6 >= SPAN_6)
        begin
            sec_next  = SEC_RED_YEL;
            frac_full = hue6 - SPAN_6;
        end
        else if (hue6 >= SPAN_5)
        begin
            sec_next  = SEC_MAG_RED;
            frac_full = hue6 - SPAN_5;
        end
        else if (hue6 >= SPAN_4)
        begin
            sec_next  = SEC_BLU_MAG;
            frac_full = hue6 - SPAN_4;
        end
        else if (hue6 >= SPAN_3)
        begin
            sec_next  = SEC_CYN_BLU;
            frac_full = hue6 - SPAN_3;
        end
        else if (hue6 >= SPAN_2)
        begin
            sec_next  = SEC_GRN_CYN;
            frac_full = hue6 - SPAN_2;
        end
        else if (hue6 >= SPAN_1)
        begin
            sec_next  = SEC_YEL_GRN;
            frac_full = hue6 - SPAN_1;
        end
        else
        begin
            sec_next  = SEC_RED_YEL;
            frac_full = hue6;
        end
    end

    assign frac   = frac_full[LEVEL_W-1:0];
    assign k_next = sec_next[0] ? (LEVEL_MAX - frac) : frac;

    always_ff @(posedge clk)
    begin
        if (rdy[1] && s_tvalid)
        begin
            sec1_reg <= sec_next;
            k1_reg   <= k_next;
            s1_reg   <= s_tdata[15:8];
            v1_reg   <= s_tdata[23:16];
        end
    end

    // stage 2: v*(255-s) and v*s
    always_ff @(posedge clk)
    begin
        if (rdy[2] && vld_reg[1])
        begin
            sec2_reg <= sec1_reg;
            k2_reg   <= k1_reg;
            v2_reg   <= v1_reg;
            a2_reg   <= {8'd0, v1_reg} * {8'd0, LEVEL_MAX - s1_reg};
            b2_reg   <= {8'd0, v1_reg} * {8'd0, s1_reg};
        end
    end

    // stage 3: 255*a + b*k
    num_t a2_x255;
    num_t bk2;

    assign a2_x255 = {a2_reg, 8'd0} - {8'd0, a2_reg};
    assign bk2     = {8'd0, b2_reg} * {16'd0, k2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[3] && vld_reg[2])
        begin
            sec3_reg <= sec2_reg;
            v3_reg   <= v2_reg;
            a3_reg   <= a2_reg;
            num3_reg <= a2_x255 + bk2;
        end
    end

    // stage 4: quotient estimate of num/255, min level
    logic [NUM_W+RECIP_W-1:0] recip_prod;

    assign recip_prod = {{RECIP_W{1'b0}}, num3_reg} * {{NUM_W{1'b0}}, RECIP_255};

    always_ff @(posedge clk)
    begin
        if (rdy[4] && vld_reg[3])
        begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v3_reg;
            lo4_reg  <= div255_small(a3_reg);
            q4_reg   <= recip_prod[NUM_W+PROD_W-1:NUM_W];
            num4_reg <= num3_reg;
        end
    end

    // stage 5: estimate is low by at most one
    num_t q4_x255;
    num_t rem4;

    assign q4_x255 = {q4_reg, 8'd0} - {8'd0, q4_reg};
    assign rem4    = num4_reg - q4_x255;

    always_ff @(posedge clk)
    begin
        if (rdy[5] && vld_reg[4])
        begin
            sec5_reg <= sec4_reg;
            v5_reg   <= v4_reg;
            lo5_reg  <= lo4_reg;
            t5_reg   <= q4_reg + ((rem4 >= {16'd0, LEVEL_MAX}) ? 16'd1 : 16'd0);
        end
    end

    // stage 6: mid level and channel order
    level_t md5;
    level_t red_next, green_next, blue_next;

    assign md5 = div255_small(t5_reg);

    always_comb
    begin
        unique case (sec5_reg)
            SEC_RED_YEL:
            begin
                red_next = v5_reg;  green_next = md5;     blue_next = lo5_reg;
            end
            SEC_YEL_GRN:
            begin
                red_next = md5;     green_next = v5_reg;  blue_next = lo5_reg;
            end
            SEC_GRN_CYN:
            begin
                red_next = lo5_reg; green_next = v5_reg;  blue_next = md5;
            end
            SEC_CYN_BLU:
            begin
                red_next = lo5_reg; green_next = md5;     blue_next = v5_reg;
            end
            SEC_BLU_MAG:
            begin
                red_next = md5;     green_next = lo5_reg; blue_next = v5_reg;
            end
            default:
            begin
                red_next = v5_reg;  green_next = lo5_reg; blue_next = md5;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6] && vld_reg[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

/* rtl/hsv_to_rgb_converter_checker.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter_checker
    import h2r_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    localparam int DEPTH = 6;

    logic [DEPTH-1:0] acc_pipe_reg;
    logic [DEPTH-1:0] rdy_pipe_reg;
    logic [23:0]      data_pipe_reg [DEPTH];
    logic             flow_full;
    level_t           old_v;
    logic             out_stall;
    logic             grey_in;
    logic             grey_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_pipe_reg <= '0;
            rdy_pipe_reg <= '0;
        end
        else
        begin
            acc_pipe_reg <= {acc_pipe_reg[DEPTH-2:0], s_tvalid && s_tready};
            rdy_pipe_reg <= {rdy_pipe_reg[DEPTH-2:0], m_tready};
        end
    end

    always_ff @(posedge clk)
    begin
        data_pipe_reg[0] <= s_tdata;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_pipe_reg[i] <= data_pipe_reg[i-1];
        end
    end

    // request that has passed through the whole acceptance pipe, with m_tready high in every cycle since
    assign flow_full = acc_pipe_reg[DEPTH-1] && (&rdy_pipe_reg[DEPTH-2:0]);
    assign old_v     = data_pipe_reg[DEPTH-1][23:16];
    assign out_stall = m_tvalid && !m_tready;
    assign grey_in   = flow_full && (data_pipe_reg[DEPTH-1][15:8] == 8'd0);
    assign grey_out  = (m_tdata[7:0] == old_v) && (m_tdata[15:8] == old_v)
                       && (m_tdata[23:16] == old_v);

    `H2R_ASSERT_RST(a_out_hold, clk, rst_n, out_stall |=> m_tvalid && $stable(m_tdata), "output not held")

    `H2R_ASSERT_RST(a_latency, clk, rst_n, flow_full |-> m_tvalid, "result missing after six free cycles")

    `H2R_ASSERT_RST(a_grey, clk, rst_n, grey_in |-> grey_out, "zero saturation not grey")

    `H2R_ASSERT(a_reset_empty, clk, !rst_n |=> !m_tvalid, "output valid right after reset")

endmodule

bind hsv_to_rgb_converter hsv_to_rgb_converter_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the pipelined HSV to RGB converter. An in-bench predictor
// computes the expected color for every accepted request. Results are
// checked in order, field by field. Traffic covers directed corner colors,
// random colors with random idling on both sides, and a long output
// hold-off that fills the pipeline and stalls the input.
// ----------------------------------------------------------------------------
module tb
    import h2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        level_t blue;
        level_t green;
        level_t red;
    } rgb_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [23:0] m_tdata;

    rgb_t color_queue[$];
    int   fail_count  = 0;
    bit   steady      = 1'b0;
    bit   sink_steady = 1'b0;
    bit   sink_hold   = 1'b0;

    hsv_to_rgb_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rgb_t hsv_to_rgb(input level_t hue, input level_t sat,
                                        input level_t val);
        int unsigned hue6;
        int unsigned frac;
        int unsigned k;
        int unsigned lo;
        int unsigned md;
        int unsigned hi;
        sector_t     sec;
        rgb_t        c;
        hue6 = 6 * hue;
        sec  = sector_t'((hue6 / 255) % 6);
        frac = hue6 % 255;
        k    = (sec == SEC_YEL_GRN || sec == SEC_CYN_BLU || sec == SEC_MAG_RED)
               ? 255 - frac : frac;
        hi   = val;
        lo   = (val * (255 - sat)) / 255;
        md   = (255 * val * (255 - sat) + val * sat * k) / 65025;
        case (sec)
            SEC_RED_YEL: c = '{blue: lo[7:0], green: md[7:0], red: hi[7:0]};
            SEC_YEL_GRN: c = '{blue: lo[7:0], green: hi[7:0], red: md[7:0]};
            SEC_GRN_CYN: c = '{blue: md[7:0], green: hi[7:0], red: lo[7:0]};
            SEC_CYN_BLU: c = '{blue: hi[7:0], green: md[7:0], red: lo[7:0]};
            SEC_BLU_MAG: c = '{blue: hi[7:0], green: lo[7:0], red: md[7:0]};
            default:     c = '{blue: md[7:0], green: lo[7:0], red: hi[7:0]};
        endcase
        return c;
    endfunction

    // predict on input accept, compare on output accept
    always @(posedge clk)
    begin : scoreboard
        rgb_t want;
        rgb_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                color_queue.push_back(hsv_to_rgb(s_tdata[7:0], s_tdata[15:8],
                                                 s_tdata[23:16]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (color_queue.size() == 0)
                begin
                    $error("unexpected result red=%0d green=%0d blue=%0d",
                           got.red, got.green, got.blue);
                    fail_count++;
                end
                else
                begin
                    want = color_queue.pop_front();
                    if (got.red !== want.red)
                    begin
                        $error("red expected %0d actual %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green)
                    begin
                        $error("green expected %0d actual %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue)
                    begin
                        $error("blue expected %0d actual %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
        m_tready <= !sink_hold && (sink_steady || $urandom_range(99) >= 21);

    // called at a rising edge; returns at the edge the request is accepted
    task automatic send_color(input level_t hue, input level_t sat, input level_t val);
        if (!steady && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, sat, hue};
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic level_t pick_level();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return level_t'($urandom_range(255));
        endcase
    endfunction

    task automatic test_corners();
        send_color(8'd0,   8'd0,   8'd0);
        send_color(8'd255, 8'd255, 8'd255);
        send_color(8'd0,   8'd255, 8'd255);
        send_color(8'd254, 8'd255, 8'd255);
        send_color(8'd42,  8'd255, 8'd255);
        send_color(8'd43,  8'd255, 8'd255);
        send_color(8'd85,  8'd255, 8'd255);
        send_color(8'd86,  8'd255, 8'd255);
        send_color(8'd127, 8'd255, 8'd255);
        send_color(8'd128, 8'd255, 8'd255);
        send_color(8'd170, 8'd255, 8'd255);
        send_color(8'd171, 8'd255, 8'd255);
        send_color(8'd212, 8'd255, 8'd255);
        send_color(8'd213, 8'd255, 8'd255);
        send_color(8'd255, 8'd200, 8'd100);
        send_color(8'd100, 8'd0,   8'd200);
        send_color(8'd200, 8'd0,   8'd77);
        send_color(8'd60,  8'd255, 8'd0);
        send_color(8'd85,  8'd170, 8'd85);
        send_color(8'd170, 8'd85,  8'd170);
        send_color(8'd30,  8'd1,   8'd255);
        send_color(8'd150, 8'd128, 8'd128);
        send_color(8'd255, 8'd0,   8'd0);
    endtask

    task automatic test_random_colors(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 3)
            begin
                steady = 1'b1;
                sink_steady <= 1'b1;
            end
            else if (i == count / 3 + 100)
            begin
                steady = 1'b0;
                sink_steady <= 1'b0;
            end
            send_color(pick_level(), pick_level(), pick_level());
        end
    endtask

    task automatic test_output_holdoff();
        steady = 1'b1;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (120) @(posedge clk);
                sink_hold <= 1'b0;
            end
        join_none
        repeat (40) send_color(pick_level(), pick_level(), pick_level());
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random_colors(440);
        test_output_holdoff();
        s_tvalid <= 1'b0;
        while (color_queue.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
